// ===== rtl/lpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page cache directory package
// Field widths, request kinds, state type and the per-cell control word.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  localparam int KIND_W   = 2;
  localparam int PAGE_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int OCC_W    = 7;

  // Request kinds; the fourth code is a no-op
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lpcd_state_t;

  // Control word handed to every cell of the row
  typedef struct packed {
    logic load;   // latch compare result against the incoming page
    logic shift;  // take the upstream neighbor's entry
    logic drop;   // invalidate this entry
    logic clear;  // empty the entry
  } lpcd_cell_ctl_t;

endpackage

// ===== rtl/lru_page_cache_directory.sv =====
// Each word is compared against every cell of the row as it is accepted; the row then
// promotes, inserts or evicts by shifting, or clears; the result word is registered as
// that update commits. A new word is taken only once the last one has committed.
// A finished result waiting on out_stall holds the next word's update until taken.
// Reset (rst_n low, synchronous) empties the directory and drops any pending
// result; entry pages and handles are not cleared.
// ----------------------------------------------------------------------------
// LRU page cache directory
// Fully associative page-to-frame directory kept as a row of cells ordered by
// recency: cell 0 is most recent, the last valid cell least recent.
// ----------------------------------------------------------------------------
module lru_page_cache_directory import lpcd_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [PAGE_W-1:0]   in_page_id,
  input  logic [HANDLE_W-1:0] in_frame_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [HANDLE_W-1:0] out_hit_handle,
  output logic                out_evicted,
  output logic [PAGE_W-1:0]   out_evicted_page,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(ENTRIES);
  localparam logic [ENTRIES-1:0] LAST_BIT = {1'b1, {(ENTRIES-1){1'b0}}};

  lpcd_state_t         state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic [PAGE_W-1:0]   page_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [HANDLE_W-1:0] out_hit_handle_r, out_hit_handle_nxt;
  logic                out_evicted_r, out_evicted_nxt;
  logic [PAGE_W-1:0]   out_evicted_page_r, out_evicted_page_nxt;
  logic [OCC_W-1:0]    out_occupancy_r, out_occupancy_nxt;

  logic                accept;
  logic                commit;
  logic                evict;
  logic                any_match;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  mvec;
  logic [ENTRIES:0]    mask_ext;
  logic [ENTRIES-1:0]  shift_vec;
  logic                drop_last;
  logic                clear_all;
  logic [HANDLE_W-1:0] sel_handle;
  logic [HANDLE_W-1:0] front_handle;
  logic [31:0]         occ_ext;

  logic                cell_valid  [ENTRIES];
  logic [PAGE_W-1:0]   cell_page   [ENTRIES];
  logic [HANDLE_W-1:0] cell_handle [ENTRIES];
  logic                up_valid    [ENTRIES];
  logic [PAGE_W-1:0]   up_page     [ENTRIES];
  logic [HANDLE_W-1:0] up_handle   [ENTRIES];
  lpcd_cell_ctl_t      cell_ctl    [ENTRIES];

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // Hold the request while the row works on it
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      page_r   <= in_page_id;
      handle_r <= in_frame_handle;
    end
  end

  // Mask the victim out of the match when a full insert evicts it first
  always_comb begin
    evict     = (kind_r == KIND_INSERT) && (count_r == FULL_CNT);
    mvec      = match_vec & ~(evict ? LAST_BIT : '0);
    any_match = |mvec;
    // cells 0..p for a one-hot match at p
    mask_ext  = {mvec, 1'b0} - {{ENTRIES{1'b0}}, 1'b1};
  end

  // Pick the handle of the matching cell
  always_comb begin
    sel_handle = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (mvec[k]) begin
        sel_handle = sel_handle | cell_handle[k];
      end
    end
  end

  // Build row controls and the next count when the request commits
  always_comb begin
    shift_vec = '0;
    drop_last = 1'b0;
    clear_all = 1'b0;
    count_nxt = count_r;
    if (commit) begin
      case (kind_r)
        KIND_LOOKUP: begin
          shift_vec = any_match ? mask_ext[ENTRIES-1:0] : '0;
        end
        KIND_INSERT: begin
          shift_vec = any_match ? mask_ext[ENTRIES-1:0] : '1;
          drop_last = evict && any_match;
          if (evict) begin
            count_nxt = any_match ? count_r - CNT_W'(1) : count_r;
          end else begin
            count_nxt = any_match ? count_r : count_r + CNT_W'(1);
          end
        end
        KIND_CLEAR: begin
          clear_all = 1'b1;
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      cell_ctl[k].load  = accept;
      cell_ctl[k].shift = shift_vec[k];
      cell_ctl[k].drop  = drop_last && (k == ENTRIES - 1);
      cell_ctl[k].clear = clear_all;
    end
  end

  // Promoted or inserted entry enters at the head of the row
  assign front_handle = (kind_r == KIND_INSERT) ? handle_r : sel_handle;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_row
      if (g == 0) begin : g_head
        assign up_valid[g]  = 1'b1;
        assign up_page[g]   = page_r;
        assign up_handle[g] = front_handle;
      end else begin : g_link
        assign up_valid[g]  = cell_valid[g-1];
        assign up_page[g]   = cell_page[g-1];
        assign up_handle[g] = cell_handle[g-1];
      end
      lpcd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cell_ctl[g]),
        .cmp_page  (in_page_id),
        .up_valid  (up_valid[g]),
        .up_page   (up_page[g]),
        .up_handle (up_handle[g]),
        .valid     (cell_valid[g]),
        .page      (cell_page[g]),
        .handle    (cell_handle[g]),
        .match     (match_vec[g])
      );
    end
  endgenerate

  // Sequence compare and update
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Form the result word
  always_comb begin
    occ_ext              = 32'(count_nxt);
    out_valid_nxt        = commit || (out_valid_r && out_stall);
    out_hit_nxt          = out_hit_r;
    out_hit_handle_nxt   = out_hit_handle_r;
    out_evicted_nxt      = out_evicted_r;
    out_evicted_page_nxt = out_evicted_page_r;
    out_occupancy_nxt    = out_occupancy_r;
    if (commit) begin
      out_hit_nxt          = (kind_r == KIND_LOOKUP) && any_match;
      out_hit_handle_nxt   = ((kind_r == KIND_LOOKUP) && any_match) ? sel_handle : '0;
      out_evicted_nxt      = evict;
      out_evicted_page_nxt = evict ? cell_page[ENTRIES-1] : '0;
      out_occupancy_nxt    = occ_ext[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r          <= out_hit_nxt;
    out_hit_handle_r   <= out_hit_handle_nxt;
    out_evicted_r      <= out_evicted_nxt;
    out_evicted_page_r <= out_evicted_page_nxt;
    out_occupancy_r    <= out_occupancy_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_handle   = out_hit_handle_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_occupancy    = out_occupancy_r;

endmodule

// ===== rtl/lpcd_cell.sv =====
// ----------------------------------------------------------------------------
// LRU directory cell
// One entry of the recency-ordered row: holds page, handle and valid, compares
// against the requested page and takes its upstream neighbor's entry on shift.
// ----------------------------------------------------------------------------
module lpcd_cell import lpcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lpcd_cell_ctl_t      ctl,
  input  logic [PAGE_W-1:0]   cmp_page,
  input  logic                up_valid,
  input  logic [PAGE_W-1:0]   up_page,
  input  logic [HANDLE_W-1:0] up_handle,
  output logic                valid,
  output logic [PAGE_W-1:0]   page,
  output logic [HANDLE_W-1:0] handle,
  output logic                match
);

  logic                valid_r, valid_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic                match_r, match_nxt;

  // Select next entry contents: clear, drop, shift from neighbor, or hold
  always_comb begin
    valid_nxt  = valid_r;
    page_nxt   = page_r;
    handle_nxt = handle_r;
    if (ctl.clear || ctl.drop) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt  = up_valid;
      page_nxt   = up_page;
      handle_nxt = up_handle;
    end
    match_nxt = ctl.load ? (valid_r && (page_r == cmp_page)) : match_r;
  end

  // Valid bit is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entry payload and compare result
  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    handle_r <= handle_nxt;
    match_r  <= match_nxt;
  end

  assign valid  = valid_r;
  assign page   = page_r;
  assign handle = handle_r;
  assign match  = match_r;

endmodule

// ===== rtl/lpcd_checker.sv =====
// ----------------------------------------------------------------------------
// LRU directory port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lpcd_port_props import lpcd_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input logic [HANDLE_W-1:0] out_hit_handle,
  input logic                out_evicted,
  input logic [OCC_W-1:0]    out_occupancy
);

  // Drop any result on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // Hold off the next word while one is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted on back-to-back cycles");

  // Keep occupancy within the directory size
  a_occupancy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_occupancy) <= ENTRIES))
    else $error("occupancy beyond directory size");

  // Never report a hit and an eviction together, nor a handle without a hit
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_hit || out_hit_handle != '0)) |-> (out_hit && !out_evicted))
    else $error("inconsistent hit and eviction fields");

  // Hold a stalled result valid with its hit handle unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hit_handle)))
    else $error("stalled result word changed");

endmodule

bind lru_page_cache_directory lpcd_port_props #(.ENTRIES(ENTRIES)) u_lpcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_hit_handle (out_hit_handle),
  .out_evicted    (out_evicted),
  .out_occupancy  (out_occupancy)
);
